// ----- sv/csi_pkg.sv -----
package csi_pkg;

   localparam int SUBCARRIERS_DEF = 30;
   localparam int MAX_PAIRS = 9;
   localparam int PAYLOAD_OFFSET = 21;
   localparam int PAIR_FIELD_W = $clog2(MAX_PAIRS + 1);

   localparam logic [3:0] KIND_TIMESTAMP = 4'd0;
   localparam logic [3:0] KIND_COUNT     = 4'd1;
   localparam logic [3:0] KIND_NRX       = 4'd2;
   localparam logic [3:0] KIND_NTX       = 4'd3;
   localparam logic [3:0] KIND_RSSI_A    = 4'd4;
   localparam logic [3:0] KIND_RSSI_B    = 4'd5;
   localparam logic [3:0] KIND_RSSI_C    = 4'd6;
   localparam logic [3:0] KIND_NOISE     = 4'd7;
   localparam logic [3:0] KIND_CSI       = 4'd8;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       record_start;
   } req_type;

   typedef struct packed {
      logic [3:0]        kind;
      logic [31:0]       header_value;
      logic [4:0]        subcarrier;
      logic [3:0]        antenna_pair;
      logic signed [7:0] real_part;
      logic signed [7:0] imag_part;
      logic              last_entry;
   } rsp_type;

   // front to back: either a finished header field or one payload byte
   typedef struct packed {
      logic                    payload;
      logic                    first;
      logic [7:0]              data_byte;
      logic [PAIR_FIELD_W-1:0] pairs;
      logic [3:0]              kind;
      logic [31:0]             header_value;
   } item_type;

endpackage

// ----- sv/csi_fifo.sv -----
module csi_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] head_ff, head_in;
   logic [WIDTH-1:0] tail_ff, tail_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = head_ff;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         if (count_ff == 2'd0) begin
            head_in = push_data;
         end else begin
            tail_in = push_data;
         end
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         head_in  = tail_ff;
         count_in = count_ff - 2'd1;
      end else if (do_pop && do_push) begin
         if (count_ff == 2'd1) begin
            head_in = push_data;
         end else begin
            head_in = tail_ff;
            tail_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

// ----- sv/csi_front.sv -----
module csi_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  csi_pkg::req_type   req_data,
   output logic               item_valid,
   output csi_pkg::item_type  item
);

   localparam int PW = csi_pkg::PAIR_FIELD_W;
   localparam logic [9:0] POS_MAX     = 10'd1023;
   localparam logic [9:0] POS_PAYLOAD = 10'(csi_pkg::PAYLOAD_OFFSET);
   localparam logic [9:0] POS_TS_0    = 10'd1;
   localparam logic [9:0] POS_TS_1    = 10'd2;
   localparam logic [9:0] POS_TS_2    = 10'd3;
   localparam logic [9:0] POS_TS_3    = 10'd4;
   localparam logic [9:0] POS_CNT_0   = 10'd5;
   localparam logic [9:0] POS_CNT_1   = 10'd6;
   localparam logic [9:0] POS_NRX     = 10'd9;
   localparam logic [9:0] POS_NTX     = 10'd10;
   localparam logic [9:0] POS_RSSI_A  = 10'd11;
   localparam logic [9:0] POS_RSSI_B  = 10'd12;
   localparam logic [9:0] POS_RSSI_C  = 10'd13;
   localparam logic [9:0] POS_NOISE   = 10'd14;

   logic          active_ff, active_in;
   logic [9:0]    pos_ff, pos_in;
   logic [23:0]   acc_ff, acc_in;
   logic [7:0]    rx_ff, rx_in;
   logic [PW-1:0] pairs_ff, pairs_in;
   logic [9:0]    pos_inc;
   logic [15:0]   prod;
   logic [PW-1:0] pairs_clamp;
   logic [7:0]    b;

   assign b = req_data.data_byte;

   always_comb begin
      pos_inc     = (pos_ff == POS_MAX) ? POS_MAX : pos_ff + 10'd1;
      prod        = 16'(rx_ff) * 16'(b);
      pairs_clamp = (prod > 16'(csi_pkg::MAX_PAIRS)) ? PW'(csi_pkg::MAX_PAIRS) : PW'(prod);

      active_in  = active_ff;
      pos_in     = pos_ff;
      acc_in     = acc_ff;
      rx_in      = rx_ff;
      pairs_in   = pairs_ff;
      item_valid = 1'b0;
      item       = '0;

      if (accept) begin
         if (req_data.record_start) begin
            active_in = 1'b1;
            pos_in    = '0;
            acc_in    = '0;
            rx_in     = '0;
            pairs_in  = '0;
         end else if (active_ff) begin
            pos_in = pos_inc;
            if (pos_inc >= POS_PAYLOAD) begin
               item_valid     = 1'b1;
               item.payload   = 1'b1;
               item.first     = (pos_inc == POS_PAYLOAD);
               item.data_byte = b;
               item.pairs     = pairs_ff;
            end else begin
               unique case (pos_inc)
                  POS_TS_0: begin
                     acc_in = {16'b0, b};
                  end
                  POS_TS_1: begin
                     acc_in[15:8] = b;
                  end
                  POS_TS_2: begin
                     acc_in[23:16] = b;
                  end
                  POS_TS_3: begin
                     item_valid        = 1'b1;
                     item.kind         = csi_pkg::KIND_TIMESTAMP;
                     item.header_value = {b, acc_ff};
                  end
                  POS_CNT_0: begin
                     acc_in = {16'b0, b};
                  end
                  POS_CNT_1: begin
                     item_valid        = 1'b1;
                     item.kind         = csi_pkg::KIND_COUNT;
                     item.header_value = {16'b0, b, acc_ff[7:0]};
                  end
                  POS_NRX: begin
                     rx_in             = b;
                     item_valid        = 1'b1;
                     item.kind         = csi_pkg::KIND_NRX;
                     item.header_value = {24'b0, b};
                  end
                  POS_NTX: begin
                     pairs_in          = pairs_clamp;
                     item_valid        = 1'b1;
                     item.kind         = csi_pkg::KIND_NTX;
                     item.header_value = {24'b0, b};
                  end
                  POS_RSSI_A: begin
                     item_valid        = 1'b1;
                     item.kind         = csi_pkg::KIND_RSSI_A;
                     item.header_value = {24'b0, b};
                  end
                  POS_RSSI_B: begin
                     item_valid        = 1'b1;
                     item.kind         = csi_pkg::KIND_RSSI_B;
                     item.header_value = {24'b0, b};
                  end
                  POS_RSSI_C: begin
                     item_valid        = 1'b1;
                     item.kind         = csi_pkg::KIND_RSSI_C;
                     item.header_value = {24'b0, b};
                  end
                  POS_NOISE: begin
                     item_valid        = 1'b1;
                     item.kind         = csi_pkg::KIND_NOISE;
                     item.header_value = {24'b0, b};
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= '0;
         acc_ff    <= '0;
         rx_ff     <= '0;
         pairs_ff  <= '0;
      end else begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
         acc_ff    <= acc_in;
         rx_ff     <= rx_in;
         pairs_ff  <= pairs_in;
      end
   end

endmodule

// ----- sv/csi_back.sv -----
module csi_back #(
   parameter int SUBCARRIERS = csi_pkg::SUBCARRIERS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  csi_pkg::item_type  item,
   output logic               item_pop,
   input  logic               out_full,
   output logic               rsp_valid,
   output csi_pkg::rsp_type   rsp
);

   localparam int PW   = csi_pkg::PAIR_FIELD_W;
   localparam int SC_W = $clog2(SUBCARRIERS + 1);

   logic [23:0]     win_ff, win_in;
   logic [4:0]      held_ff, held_in;
   logic [SC_W-1:0] sc_ff, sc_in;
   logic [PW-1:0]   pc_ff, pc_in;
   logic            skip_ff, skip_in;
   logic            done_ff, done_in;

   logic [23:0]     win_base, win_add, win_skip;
   logic [4:0]      held_base, held_add, held_skip;
   logic [SC_W-1:0] sc_base, sc_next;
   logic [PW-1:0]   pc_base, pc_next;
   logic            skip_base, done_base, emit, last;

   assign item_pop = item_valid && !out_full;

   always_comb begin
      win_base  = item.first ? '0 : win_ff;
      held_base = item.first ? '0 : held_ff;
      sc_base   = item.first ? '0 : sc_ff;
      pc_base   = item.first ? '0 : pc_ff;
      skip_base = item.first ? 1'b1 : skip_ff;
      done_base = item.first ? 1'b0 : done_ff;

      win_add   = win_base | (24'(item.data_byte) << held_base);
      held_add  = held_base + 5'd8;
      win_skip  = skip_base ? (win_add >> 3) : win_add;
      held_skip = skip_base ? (held_add - 5'd3) : held_add;
      emit      = (held_skip >= 5'd16);
      pc_next   = pc_base + PW'(1);
      sc_next   = sc_base + SC_W'(1);
      last      = (sc_next >= SC_W'(SUBCARRIERS)) && (pc_next >= item.pairs);

      win_in    = win_ff;
      held_in   = held_ff;
      sc_in     = sc_ff;
      pc_in     = pc_ff;
      skip_in   = skip_ff;
      done_in   = done_ff;
      rsp_valid = 1'b0;
      rsp       = '0;

      if (item_pop) begin
         if (!item.payload) begin
            rsp_valid        = 1'b1;
            rsp.kind         = item.kind;
            rsp.header_value = item.header_value;
         end else begin
            win_in  = win_base;
            held_in = held_base;
            sc_in   = sc_base;
            pc_in   = pc_base;
            skip_in = skip_base;
            done_in = done_base;
            if (!done_base) begin
               if (item.pairs == '0) begin
                  done_in = 1'b1;
               end else begin
                  win_in  = win_skip;
                  held_in = held_skip;
                  skip_in = 1'b0;
                  if (emit) begin
                     rsp_valid        = 1'b1;
                     rsp.kind         = csi_pkg::KIND_CSI;
                     rsp.subcarrier   = 5'(sc_base);
                     rsp.antenna_pair = 4'(pc_base);
                     rsp.real_part    = win_skip[7:0];
                     rsp.imag_part    = win_skip[15:8];
                     rsp.last_entry   = last;
                     win_in           = win_skip >> 16;
                     held_in          = held_skip - 5'd16;
                     if (pc_next >= item.pairs) begin
                        pc_in   = '0;
                        sc_in   = sc_next;
                        skip_in = 1'b1;
                     end else begin
                        pc_in = pc_next;
                     end
                     if (last) begin
                        done_in = 1'b1;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= '0;
         held_ff <= '0;
         sc_ff   <= '0;
         pc_ff   <= '0;
         skip_ff <= 1'b1;
         done_ff <= 1'b1;
      end else begin
         win_ff  <= win_in;
         held_ff <= held_in;
         sc_ff   <= sc_in;
         pc_ff   <= pc_in;
         skip_ff <= skip_in;
         done_ff <= done_in;
      end
   end

endmodule

// ----- sv/csi_record_unpacker.sv -----
// A byte accepted at a rising edge has its result (if any) registered in the
// classify queue and then in the result queue before it reaches the result ports.
// Throughput: one byte per cycle, set by the one-byte-per-cycle bit unpacker;
// input stalls only when the classify queue fills behind a full result queue.
// Reset (synchronous, active high) empties both queues and leaves the parser
// idle until a byte flagged as record start arrives.
module csi_record_unpacker #(
   parameter int SUBCARRIERS = csi_pkg::SUBCARRIERS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  csi_pkg::req_type  req_data,
   output logic              empty,
   input  logic              pop,
   output csi_pkg::rsp_type  rsp_data
);

   localparam int ITEM_W = $bits(csi_pkg::item_type);
   localparam int RSP_W  = $bits(csi_pkg::rsp_type);

   logic              accept;
   logic              front_valid;
   csi_pkg::item_type front_item;
   logic              mid_full, mid_empty, mid_pop;
   logic [ITEM_W-1:0] mid_data;
   csi_pkg::item_type back_item;
   logic              out_full, back_valid;
   csi_pkg::rsp_type  back_rsp;
   logic [RSP_W-1:0]  out_data;

   assign full      = mid_full;
   assign accept    = push && !mid_full;
   assign back_item = csi_pkg::item_type'(mid_data);
   assign rsp_data  = csi_pkg::rsp_type'(out_data);

   csi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .item_valid (front_valid),
      .item       (front_item)
   );

   csi_fifo #(.WIDTH(ITEM_W)) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_data),
      .empty     (mid_empty)
   );

   csi_back #(.SUBCARRIERS(SUBCARRIERS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!mid_empty),
      .item       (back_item),
      .item_pop   (mid_pop),
      .out_full   (out_full),
      .rsp_valid  (back_valid),
      .rsp        (back_rsp)
   );

   csi_fifo #(.WIDTH(RSP_W)) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (back_valid),
      .push_data (back_rsp),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (out_data),
      .empty     (empty)
   );

endmodule

// ----- sv/csi_checker.sv -----
module csi_checker (
   input logic              clock,
   input logic              reset,
   input logic              empty,
   input logic              pop,
   input csi_pkg::rsp_type  rsp_data
);

   a_reset_empty : assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed before transfer");

   a_kind_range : assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.kind <= csi_pkg::KIND_CSI))
      else $error("result kind out of range");

   a_header_clean : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.kind != csi_pkg::KIND_CSI) |->
      (rsp_data.subcarrier == '0 && rsp_data.antenna_pair == '0 &&
       rsp_data.real_part == '0 && rsp_data.imag_part == '0 && !rsp_data.last_entry))
      else $error("header result carries csi fields");

   a_csi_no_header : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.kind == csi_pkg::KIND_CSI) |-> (rsp_data.header_value == '0))
      else $error("csi entry carries a header value");

endmodule

bind csi_record_unpacker csi_checker u_csi_checker (.*);

// ----- bench/csi_record_unpacker_tb.sv -----
module csi_record_unpacker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import csi_pkg::*;

   localparam int SUBCARRIER_COUNT = SUBCARRIERS_DEF;
   localparam int POS_LIMIT        = 1023;
   localparam int ITEM_TARGET      = 1100;
   localparam int CYCLE_LIMIT      = 500000;
   localparam int PRESSURE_HOLD    = 300;
   localparam int MAX_REPORTS      = 200;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    push     = 1'b0;
   logic    full;
   req_type req_data = '0;
   logic    empty;
   logic    pop      = 1'b0;
   rsp_type rsp_data;

   csi_record_unpacker #(
      .SUBCARRIERS(SUBCARRIER_COUNT)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser state mirror
   logic [9:0]  rec_pos;
   logic [31:0] hdr_acc;
   logic [7:0]  nrx_val;
   logic [7:0]  ntx_val;
   logic [23:0] bit_buf;
   logic [4:0]  bit_cnt;
   logic [4:0]  sc_idx;
   logic [3:0]  pair_idx;
   logic        skip_due;
   logic        parser_idle;

   rsp_type pending_fields[$];

   int error_count     = 0;
   int cycle_count     = 0;
   int items_used      = 0;
   int bytes_ignored   = 0;
   int records_started = 0;
   int headers_checked = 0;
   int entries_checked = 0;
   int records_closed  = 0;

   bit tx_idle_on      = 1'b1;
   bit rx_idle_on      = 1'b1;
   int rx_hold_request = 0;
   int rx_hold_left    = 0;
   int rx_stall_left   = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      else if (r < 95) return $urandom_range(4, 12);
      else return $urandom_range(30, 80);
   endfunction

   function automatic int full_record_len(input int pairs);
      return PAYLOAD_OFFSET + (SUBCARRIER_COUNT * (3 + 16 * pairs) + 7) / 8;
   endfunction

   task automatic restart_parser();
      rec_pos  = '0;
      hdr_acc  = '0;
      nrx_val  = '0;
      ntx_val  = '0;
      bit_buf  = '0;
      bit_cnt  = '0;
      sc_idx   = '0;
      pair_idx = '0;
      skip_due = 1'b1;
   endtask

   task automatic parse_record_byte(input logic [7:0] b, input logic start, output bit used);
      rsp_type     r;
      bit          emit;
      int unsigned pairs;
      r    = '0;
      emit = 1'b0;
      used = 1'b1;
      if (start) begin
         restart_parser();
         parser_idle = 1'b0;
         return;
      end
      if (parser_idle) begin
         used = 1'b0;
         return;
      end
      if (rec_pos < POS_LIMIT) rec_pos = rec_pos + 10'd1;
      if (rec_pos >= PAYLOAD_OFFSET) begin
         pairs = int'(nrx_val) * int'(ntx_val);
         if (pairs > MAX_PAIRS) pairs = MAX_PAIRS;
         if (pairs == 0) begin
            parser_idle = 1'b1;
            return;
         end
         bit_buf = bit_buf | (24'(b) << bit_cnt);
         bit_cnt = bit_cnt + 5'd8;
         if (skip_due && bit_cnt >= 3) begin
            bit_buf  = bit_buf >> 3;
            bit_cnt  = bit_cnt - 5'd3;
            skip_due = 1'b0;
         end
         if (!skip_due && bit_cnt >= 16) begin
            emit           = 1'b1;
            r.kind         = KIND_CSI;
            r.subcarrier   = sc_idx;
            r.antenna_pair = pair_idx;
            r.real_part    = bit_buf[7:0];
            r.imag_part    = bit_buf[15:8];
            r.last_entry   = (sc_idx + 1 >= SUBCARRIER_COUNT) && (pair_idx + 1 >= pairs);
            bit_buf        = bit_buf >> 16;
            bit_cnt        = bit_cnt - 5'd16;
            pair_idx       = pair_idx + 4'd1;
            if (pair_idx >= pairs) begin
               pair_idx = '0;
               sc_idx   = sc_idx + 5'd1;
               skip_due = 1'b1;
            end
            if (r.last_entry) parser_idle = 1'b1;
         end
      end else begin
         case (rec_pos)
            1: hdr_acc = 32'(b);
            2, 3: hdr_acc = hdr_acc | (32'(b) << (8 * (rec_pos - 1)));
            4: begin
               hdr_acc = hdr_acc | (32'(b) << 24);
               emit = 1'b1;
               r.kind = KIND_TIMESTAMP;
               r.header_value = hdr_acc;
            end
            5: hdr_acc = 32'(b);
            6: begin
               hdr_acc = (hdr_acc | (32'(b) << 8)) & 32'h0000_FFFF;
               emit = 1'b1;
               r.kind = KIND_COUNT;
               r.header_value = hdr_acc;
            end
            9: begin
               nrx_val = b;
               emit = 1'b1;
               r.kind = KIND_NRX;
               r.header_value = 32'(b);
            end
            10: begin
               ntx_val = b;
               emit = 1'b1;
               r.kind = KIND_NTX;
               r.header_value = 32'(b);
            end
            11: begin
               emit = 1'b1;
               r.kind = KIND_RSSI_A;
               r.header_value = 32'(b);
            end
            12: begin
               emit = 1'b1;
               r.kind = KIND_RSSI_B;
               r.header_value = 32'(b);
            end
            13: begin
               emit = 1'b1;
               r.kind = KIND_RSSI_C;
               r.header_value = 32'(b);
            end
            14: begin
               emit = 1'b1;
               r.kind = KIND_NOISE;
               r.header_value = 32'(b);
            end
            default: ;
         endcase
      end
      if (emit) pending_fields.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (pending_fields.size() == 0) begin
            report_mismatch("unexpected transfer, kind", 32'(rsp_data.kind), '0);
         end else begin
            want = pending_fields.pop_front();
            if (rsp_data.kind !== want.kind)
               report_mismatch("kind", 32'(rsp_data.kind), 32'(want.kind));
            if (rsp_data.header_value !== want.header_value)
               report_mismatch("header_value", rsp_data.header_value, want.header_value);
            if (rsp_data.subcarrier !== want.subcarrier)
               report_mismatch("subcarrier", 32'(rsp_data.subcarrier), 32'(want.subcarrier));
            if (rsp_data.antenna_pair !== want.antenna_pair)
               report_mismatch("antenna_pair", 32'(rsp_data.antenna_pair),
                               32'(want.antenna_pair));
            if (rsp_data.real_part !== want.real_part)
               report_mismatch("real_part", {24'b0, rsp_data.real_part},
                               {24'b0, want.real_part});
            if (rsp_data.imag_part !== want.imag_part)
               report_mismatch("imag_part", {24'b0, rsp_data.imag_part},
                               {24'b0, want.imag_part});
            if (rsp_data.last_entry !== want.last_entry)
               report_mismatch("last_entry", 32'(rsp_data.last_entry), 32'(want.last_entry));
            if (want.kind == KIND_CSI) entries_checked++;
            else headers_checked++;
            if (want.last_entry) records_closed++;
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin : drive_pop
      if (rx_hold_request != 0) begin
         rx_hold_left    = rx_hold_request;
         rx_hold_request = 0;
      end
      if (rx_hold_left != 0) begin
         rx_hold_left--;
         pop <= 1'b0;
      end else if (rx_stall_left != 0) begin
         rx_stall_left--;
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
         if (rx_idle_on && $urandom_range(0, 3) == 0) rx_stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_fields.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic start);
      bit used;
      int gap;
      req_data <= '{data_byte: b, record_start: start};
      push     <= 1'b1;
      do @(posedge clock); while (full);
      parse_record_byte(b, start, used);
      if (used) items_used++;
      else bytes_ignored++;
      if (start) records_started++;
      gap = 0;
      if (tx_idle_on && $urandom_range(0, 2) == 0) gap = pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // start byte plus bytes 1 .. nbytes-1, antenna counts at bytes 9 and 10
   task automatic send_record(input logic [7:0] nrx, input logic [7:0] ntx, input int nbytes);
      send_byte(8'($urandom), 1'b1);
      for (int p = 1; p < nbytes; p++)
         send_byte(p == 9 ? nrx : (p == 10 ? ntx : 8'($urandom)), 1'b0);
   endtask

   task automatic test_idle_bytes();
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
   endtask

   // header extremes; no antenna pairs so the first payload byte ends it
   task automatic test_header_extremes();
      logic [7:0] hdr [1:22] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h5A, 8'hA5,
                                 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h7F, 8'h80, 8'h01, 8'h02,
                                 8'h04, 8'h08, 8'h10, 8'h20, 8'hC3, 8'h3C};
      send_byte(8'h00, 1'b1);
      for (int p = 1; p <= 22; p++) send_byte(hdr[p], 1'b0);
   endtask

   // antenna product 12 clamps to the pair limit; receiver holds off meanwhile
   task automatic test_clamped_record_under_pressure();
      tx_idle_on      = 1'b0;
      rx_hold_request = PRESSURE_HOLD;
      send_record(8'd4, 8'd3, full_record_len(MAX_PAIRS) + 2);
      tx_idle_on      = 1'b1;
   endtask

   task automatic test_random_records();
      int         sel;
      logic [7:0] nrx;
      logic [7:0] ntx;
      while (items_used < ITEM_TARGET) begin
         tx_idle_on = $urandom_range(0, 3) != 0;
         rx_idle_on = $urandom_range(0, 3) != 0;
         sel = $urandom_range(0, 99);
         if (sel < 55) begin
            nrx = 8'd1;
            ntx = 8'd1;
            if ($urandom_range(0, 3) == 0) begin
               if ($urandom_range(0, 1) != 0) nrx = 8'd2;
               else ntx = 8'd2;
            end
            send_record(nrx, ntx, full_record_len(int'(nrx) * int'(ntx)) +
                        $urandom_range(0, 3));
         end else if (sel < 75) begin
            // cut short at any point, then restarted by the next record
            send_record(8'($urandom), 8'($urandom), $urandom_range(1, PAYLOAD_OFFSET + 40));
         end else if (sel < 88) begin
            if ($urandom_range(0, 1) != 0)
               send_record(8'd0, 8'($urandom), PAYLOAD_OFFSET + $urandom_range(1, 3));
            else
               send_record(8'($urandom), 8'd0, PAYLOAD_OFFSET + $urandom_range(1, 3));
         end else begin
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 1'b0);
         end
      end
   endtask

   initial begin
      restart_parser();
      parser_idle = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_idle_bytes();
      test_header_extremes();
      test_clamped_record_under_pressure();
      test_random_records();

      push <= 1'b0;
      while (pending_fields.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d record bytes (%0d ignored while idle) in %0d records",
               items_used, bytes_ignored, records_started);
      $display("Checked %0d header fields and %0d csi entries, %0d records ran to the end",
               headers_checked, entries_checked, records_closed);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- csi_record_unpacker.f -----
sv/csi_pkg.sv
sv/csi_fifo.sv
sv/csi_front.sv
sv/csi_back.sv
sv/csi_record_unpacker.sv
sv/csi_checker.sv
bench/csi_record_unpacker_tb.sv
